>>> src/owcm_pkg.sv
// shared types, constants and arithmetic helpers for the omni wheel command mixer
package owcm_pkg;

  // configuration register index (byte address bit 2)
  typedef enum logic {
    REG_DEAD_ZONE   = 1'b0,
    REG_MOTOR_LIMIT = 1'b1
  } reg_idx_e;

  // turn code on the result channel
  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_RIGHT = 2'd1,
    TURN_LEFT  = 2'd2
  } turn_e;

  // which comma-separated token is being parsed
  typedef enum logic [1:0] {
    FN_X    = 2'd0,
    FN_Y    = 2'd1,
    FN_REST = 2'd2,
    FN_END  = 2'd3
  } field_num_e;

  // progress inside the current token
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_BLANK  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } field_phase_e;

  // character codes
  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_L       = 8'h4C;

  // reset values of the configuration registers
  localparam logic [14:0] DEAD_ZONE_RST   = 15'd20;
  localparam logic [14:0] MOTOR_LIMIT_RST = 15'd15000;

  // 100*sin(45 deg) in Q16
  localparam logic [22:0] MIX_GAIN_Q16 = 23'd4634095;
  localparam logic signed [20:0] AXIS_SAT = 21'sd32767;

  // text length counter saturates here (only "exactly one" matters)
  localparam logic [1:0] TEXT_MANY = 2'd2;

  // white space as skipped before a token
  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // acc*10 +- digit, saturated to +-32767
  function automatic logic signed [15:0] digit_step(logic signed [15:0] acc,
                                                    logic [3:0] d, logic neg);
    logic signed [20:0] v;
    logic signed [20:0] dd;
    dd = $signed({17'd0, d});
    v  = $signed({{5{acc[15]}}, acc}) * 21'sd10;
    v  = neg ? v - dd : v + dd;
    if (v > AXIS_SAT) v = AXIS_SAT;
    if (v < -AXIS_SAT) v = -AXIS_SAT;
    return v[15:0];
  endfunction

  // trunc(sum*gain/65536) clamped to +-limit
  function automatic logic signed [15:0] mix_wheel(logic signed [16:0] sum,
                                                   logic [14:0] limit);
    logic signed [40:0] prod;
    logic signed [40:0] biased;
    logic signed [24:0] quo;
    logic signed [24:0] lim;
    prod   = $signed({{24{sum[16]}}, sum}) * $signed({18'd0, MIX_GAIN_Q16});
    // round toward zero for negative products
    biased = prod[40] ? prod + 41'sd65535 : prod;
    quo    = biased[40:16];
    lim    = $signed({10'd0, limit});
    if (quo > lim) quo = lim;
    if (quo < -lim) quo = -lim;
    return quo[15:0];
  endfunction

endpackage

>>> src/omni_wheel_command_mixer.sv
// omni wheel command mixer: line parser, mix stage and result register
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------------------------
//   input    | in        | in_valid_i/in_stall_o  | char_in_i
//   result   | out       | out_valid_o/out_stall_i| wheel_one_o..wheel_four_o, turning_o
//   config   | in        | APB psel/penable       | paddr, pwdata, prdata
//
// one character is taken per cycle while in_stall_o is low; each character updates the line parser in that cycle
// a newline that ends a non-empty line passes through one mix register (sums, dead zone,
// turn code) and one result register (multiply, truncate, clamp)
// reset clears the line state and the pipeline and loads the register defaults
// a stalled result holds; input stalls only when both the mix and result stages are full and the result is stalled
module omni_wheel_command_mixer #(
  parameter int unsigned LINE_MAX = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // character input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        char_in_i,
  // wheel results
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [15:0] wheel_one_o,
  output logic signed [15:0] wheel_two_o,
  output logic signed [15:0] wheel_three_o,
  output logic signed [15:0] wheel_four_o,
  output logic [1:0]        turning_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import owcm_pkg::*;

  localparam int unsigned LEN_W = $clog2(LINE_MAX + 1);

  // configuration registers
  logic [14:0] dead_zone_q, motor_limit_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  // line parser state
  logic [LEN_W-1:0]  len_q, len_d;
  logic [1:0]        text_q, text_d;
  logic [7:0]        first_q, first_d;
  logic signed [15:0] x_q, x_d, y_q, y_d;
  field_num_e        fnum_q, fnum_d;
  field_phase_e      phase_q, phase_d;
  logic              neg_q, neg_d;

  // mix stage
  logic              mix_valid_q;
  turn_e             mix_turn_q;
  logic              mix_zero_q;
  logic signed [16:0] mix_sum_q [4];

  // result stage
  logic              out_valid_q;
  logic signed [15:0] wheel_q [4];
  turn_e             turn_q;

  // handshake
  logic in_fire, is_nl, line_done, mix_ready, res_ready;
  logic digit_ok, add_en;
  logic [3:0] digit_val;
  logic signed [15:0] acc_next;
  logic signed [16:0] x_ext, y_ext, dz_ext;
  logic in_dz;
  turn_e line_turn;

  assign res_ready  = !out_valid_q || !out_stall_i;
  assign mix_ready  = !mix_valid_q || res_ready;
  assign in_stall_o = !mix_ready;
  assign in_fire    = in_valid_i && mix_ready;
  assign is_nl      = (char_in_i == CH_NEWLINE);
  assign line_done  = in_fire && is_nl && (len_q != LEN_W'(0));

  // apb access
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_DEAD_ZONE:   prdata = {17'd0, dead_zone_q};
      REG_MOTOR_LIMIT: prdata = {17'd0, motor_limit_q};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q   <= DEAD_ZONE_RST;
      motor_limit_q <= MOTOR_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DEAD_ZONE:   dead_zone_q   <= pwdata[14:0];
        REG_MOTOR_LIMIT: motor_limit_q <= pwdata[14:0];
        default:         ;
      endcase
    end
  end

  // digit accumulate for the active token
  assign digit_ok  = (char_in_i >= CH_ZERO) && (char_in_i <= CH_NINE);
  assign digit_val = 4'(char_in_i - CH_ZERO);
  assign acc_next  = digit_step((fnum_q == FN_X) ? x_q : y_q, digit_val, neg_q);

  // line parser next state
  always_comb begin
    len_d   = len_q;
    text_d  = text_q;
    first_d = first_q;
    x_d     = x_q;
    y_d     = y_q;
    fnum_d  = fnum_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    add_en  = 1'b0;
    if (in_fire) begin
      if (is_nl) begin
        len_d   = '0;
        text_d  = '0;
        first_d = '0;
        x_d     = '0;
        y_d     = '0;
        fnum_d  = FN_X;
        phase_d = PH_START;
        neg_d   = 1'b0;
      end else if (len_q < LEN_W'(LINE_MAX)) begin
        len_d = len_q + LEN_W'(1);
        if (len_q == LEN_W'(0)) first_d = char_in_i;
        if (fnum_q != FN_END) begin
          if (char_in_i == CH_NUL) begin
            // a zero byte ends the text
            fnum_d = FN_END;
          end else begin
            if (text_q != TEXT_MANY) text_d = text_q + 2'd1;
            if (char_in_i == CH_COMMA) begin
              if (phase_q != PH_START) begin
                if (fnum_q == FN_X) fnum_d = FN_Y;
                else if (fnum_q == FN_Y) fnum_d = FN_REST;
              end
              phase_d = PH_START;
              neg_d   = 1'b0;
            end else if (phase_q == PH_START || phase_q == PH_BLANK) begin
              phase_d = PH_BLANK;
              if (is_blank(char_in_i)) begin
                phase_d = PH_BLANK;
              end else if (char_in_i == CH_PLUS || char_in_i == CH_MINUS) begin
                neg_d   = (char_in_i == CH_MINUS);
                phase_d = PH_DIGITS;
              end else if (digit_ok) begin
                phase_d = PH_DIGITS;
                add_en  = 1'b1;
              end else begin
                phase_d = PH_DONE;
              end
            end else if (phase_q == PH_DIGITS) begin
              if (digit_ok) add_en = 1'b1;
              else phase_d = PH_DONE;
            end
          end
        end
      end
    end
    if (add_en) begin
      if (fnum_q == FN_X) x_d = acc_next;
      else if (fnum_q == FN_Y) y_d = acc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      text_q  <= '0;
      first_q <= '0;
      x_q     <= '0;
      y_q     <= '0;
      fnum_q  <= FN_X;
      phase_q <= PH_START;
      neg_q   <= 1'b0;
    end else begin
      len_q   <= len_d;
      text_q  <= text_d;
      first_q <= first_d;
      x_q     <= x_d;
      y_q     <= y_d;
      fnum_q  <= fnum_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
    end
  end

  // line classification at newline
  assign x_ext  = {x_q[15], x_q};
  assign y_ext  = {y_q[15], y_q};
  assign dz_ext = $signed({2'b00, dead_zone_q});
  assign in_dz  = (x_ext < dz_ext) && (x_ext > -dz_ext) &&
                  (y_ext < dz_ext) && (y_ext > -dz_ext);

  always_comb begin
    line_turn = TURN_NONE;
    if (text_q == 2'd1) begin
      if (first_q == CH_R) line_turn = TURN_RIGHT;
      else if (first_q == CH_L) line_turn = TURN_LEFT;
    end
  end

  // mix stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_valid_q <= 1'b0;
    end else if (line_done) begin
      mix_valid_q <= 1'b1;
    end else if (res_ready) begin
      mix_valid_q <= 1'b0;
    end
  end

  // mix stage payload: wheel sums and line kind
  always_ff @(posedge clk_i) begin
    if (line_done) begin
      mix_turn_q   <= line_turn;
      mix_zero_q   <= in_dz;
      mix_sum_q[0] <= x_ext - y_ext;
      mix_sum_q[1] <= -x_ext - y_ext;
      mix_sum_q[2] <= -x_ext + y_ext;
      mix_sum_q[3] <= x_ext + y_ext;
    end
  end

  // result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= mix_valid_q;
    end
  end

  // result stage payload: +limit or -limit for turns, zero in the dead zone, else gain, truncate, clamp
  always_ff @(posedge clk_i) begin
    if (res_ready && mix_valid_q) begin
      turn_q <= mix_turn_q;
      for (int i = 0; i < 4; i++) begin
        case (mix_turn_q)
          TURN_RIGHT: wheel_q[i] <= $signed({1'b0, motor_limit_q});
          TURN_LEFT:  wheel_q[i] <= -$signed({1'b0, motor_limit_q});
          default: begin
            if (mix_zero_q) wheel_q[i] <= '0;
            else wheel_q[i] <= mix_wheel(mix_sum_q[i], motor_limit_q);
          end
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wheel_one_o   = wheel_q[0];
  assign wheel_two_o   = wheel_q[1];
  assign wheel_three_o = wheel_q[2];
  assign wheel_four_o  = wheel_q[3];
  assign turning_o     = turn_q;

  // line length never passes the line limit
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(LINE_MAX))
    else $error("line length above limit");

  // input stalls only behind a full, stalled pipeline
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (mix_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in pipeline");

  // right turn results drive wheels one and four at the limit
  a_turn_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && turning_o == TURN_RIGHT) |->
      (wheel_one_o == $signed({1'b0, motor_limit_q}) && wheel_four_o == wheel_one_o))
    else $error("right turn wheel value wrong");

  // results with no turn keep wheel two inside the limit
  a_mix_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && turning_o == TURN_NONE) |->
      (wheel_two_o <= $signed({1'b0, motor_limit_q}) &&
       wheel_two_o >= -$signed({1'b0, motor_limit_q})))
    else $error("mixed wheel outside limit");

endmodule

>>> tb/testbench.sv
// self-checking testbench for the omni wheel command mixer: directed lines, then random traffic
module testbench;
  import owcm_pkg::*;

  localparam int          LINE_LIMIT  = 15;
  localparam longint      MIX_GAIN    = 4634095;
  localparam int          AXIS_LIMIT  = 32767;
  localparam int          HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int          PHASE_ITEMS = 300;

  // one wheel command as seen on the result channel
  typedef struct {
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    logic signed [15:0] w3;
    logic signed [15:0] w4;
    turn_e              turn;
  } wheel_cmd_t;

  // one directed line, with a typed command where it is obvious
  typedef struct {
    string      text;
    int         nul_at;
    bit         fixed;
    wheel_cmd_t want;
  } line_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         char_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] wheel_one_o;
  logic signed [15:0] wheel_two_o;
  logic signed [15:0] wheel_three_o;
  logic signed [15:0] wheel_four_o;
  logic [1:0]         turning_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  omni_wheel_command_mixer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_in_i     (char_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .wheel_one_o   (wheel_one_o),
    .wheel_two_o   (wheel_two_o),
    .wheel_three_o (wheel_three_o),
    .wheel_four_o  (wheel_four_o),
    .turning_o     (turning_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // expected wheel commands, oldest first
  wheel_cmd_t  pending_cmds[$];
  int          error_count;
  int          items_used;
  int unsigned cycle_count;

  // idling controls
  bit in_idle_on;
  bit out_idle_on;
  int hold_req;

  // mixer model state
  logic [14:0]  dz_cfg;
  logic [14:0]  lim_cfg;
  int           line_len;
  int           text_len;
  logic [7:0]   first_ch;
  int           x_acc;
  int           y_acc;
  field_num_e   fnum;
  field_phase_e fphase;
  bit           fneg;

  line_row_t    rows[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  function automatic int pick_gap(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // line state back to empty
  task automatic clear_line();
    line_len = 0;
    text_len = 0;
    first_ch = 8'd0;
    x_acc    = 0;
    y_acc    = 0;
    fnum     = FN_X;
    fphase   = PH_START;
    fneg     = 1'b0;
  endtask

  // accumulate one digit into the current axis, saturating
  task automatic add_digit(input int d);
    int v;
    if (fnum == FN_X) begin
      v = x_acc * 10 + (fneg ? -d : d);
    end else if (fnum == FN_Y) begin
      v = y_acc * 10 + (fneg ? -d : d);
    end else begin
      return;
    end
    if (v > AXIS_LIMIT) v = AXIS_LIMIT;
    if (v < -AXIS_LIMIT) v = -AXIS_LIMIT;
    if (fnum == FN_X) x_acc = v;
    else y_acc = v;
  endtask

  // tokenizer for stored bytes
  task automatic parse_text(input logic [7:0] c);
    if (fnum == FN_END) return;
    if (c == CH_NUL) begin
      fnum = FN_END;
      return;
    end
    text_len++;
    if (c == CH_COMMA) begin
      if (fphase != PH_START && (fnum == FN_X || fnum == FN_Y)) fnum = field_num_e'(fnum + 2'd1);
      fphase = PH_START;
      fneg   = 1'b0;
      return;
    end
    if (fphase == PH_START) fphase = PH_BLANK;
    if (fphase == PH_BLANK) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        fneg   = (c == CH_MINUS);
        fphase = PH_DIGITS;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        fphase = PH_DIGITS;
        add_digit(int'(c - CH_ZERO));
      end else begin
        fphase = PH_DONE;
      end
    end else if (fphase == PH_DIGITS) begin
      if (c >= CH_ZERO && c <= CH_NINE) add_digit(int'(c - CH_ZERO));
      else fphase = PH_DONE;
    end
  endtask

  // trunc(sum * gain / 65536) clamped to the motor limit
  function automatic logic signed [15:0] wheel_speed(input int sum);
    longint v;
    longint lim;
    v   = (longint'(sum) * MIX_GAIN) / 64'sd65536;
    lim = longint'(lim_cfg);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  // advance the mixer model by one character; used is low for ignored bytes
  task automatic take_char(input logic [7:0] c, output bit used);
    wheel_cmd_t cmd;
    int         dz;
    used = 1'b0;
    if (c != CH_NEWLINE) begin
      if (line_len < LINE_LIMIT) begin
        if (line_len == 0) first_ch = c;
        line_len++;
        parse_text(c);
        used = 1'b1;
      end
      return;
    end
    if (line_len == 0) return;
    used = 1'b1;
    if (text_len == 1 && (first_ch == CH_R || first_ch == CH_L)) begin
      cmd.w1   = (first_ch == CH_R) ? $signed({1'b0, lim_cfg}) : -$signed({1'b0, lim_cfg});
      cmd.w2   = cmd.w1;
      cmd.w3   = cmd.w1;
      cmd.w4   = cmd.w1;
      cmd.turn = (first_ch == CH_R) ? TURN_RIGHT : TURN_LEFT;
    end else begin
      dz       = int'(dz_cfg);
      cmd.turn = TURN_NONE;
      if (x_acc < dz && x_acc > -dz && y_acc < dz && y_acc > -dz) begin
        cmd.w1 = 16'sd0;
        cmd.w2 = 16'sd0;
        cmd.w3 = 16'sd0;
        cmd.w4 = 16'sd0;
      end else begin
        cmd.w1 = wheel_speed(x_acc - y_acc);
        cmd.w2 = wheel_speed(-x_acc - y_acc);
        cmd.w3 = wheel_speed(-x_acc + y_acc);
        cmd.w4 = wheel_speed(x_acc + y_acc);
      end
    end
    pending_cmds.push_back(cmd);
    clear_line();
  endtask

  // offer one character after a gap and wait until it is taken
  task automatic send_char(input logic [7:0] c, input int gap);
    bit used;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    char_in_i  = c;
    do @(posedge clk_i); while (in_stall_o);
    take_char(c, used);
    if (used) items_used++;
  endtask

  // register write over the apb port, upper data bits are don't care
  task automatic write_reg(input reg_idx_e idx, input logic [14:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = ($urandom() & 32'hFFFF_8000) | {17'd0, val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_DEAD_ZONE) dz_cfg = val;
    else lim_cfg = val;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // stop offering and let every outstanding command come out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic add_row(input string text, input int nul_at, input bit fixed,
                         input int w1, input int w2, input int w3, input int w4,
                         input turn_e turn);
    line_row_t r;
    r.text      = text;
    r.nul_at    = nul_at;
    r.fixed     = fixed;
    r.want.w1   = w1[15:0];
    r.want.w2   = w2[15:0];
    r.want.w3   = w3[15:0];
    r.want.w4   = w4[15:0];
    r.want.turn = turn;
    rows.push_back(r);
  endtask

  // one numeric token with optional blanks, sign and junk
  task automatic append_token(ref logic [7:0] ln[$]);
    int    n;
    string s;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
      ln.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
    end
    case ($urandom_range(0, 9))
      0, 1:    ln.push_back(CH_MINUS);
      2:       ln.push_back(CH_PLUS);
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0:       n = $urandom_range(0, 60);
      1:       n = int'(dz_cfg) + $urandom_range(0, 2) - 1;
      2:       n = $urandom_range(0, 40000);
      default: n = $urandom_range(0, 9999999);
    endcase
    if (n < 0) n = 0;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) ln.push_back(s[i]);
    if ($urandom_range(0, 19) == 0) ln.push_back(8'h61);
  endtask

  // one random line, mostly well-formed, ending in a newline
  task automatic build_line(ref logic [7:0] ln[$]);
    int r;
    ln.delete();
    r = $urandom_range(0, 99);
    if (r < 4) begin
      // empty line
    end else if (r < 12) begin
      ln.push_back(($urandom_range(0, 1) == 0) ? CH_R : CH_L);
      if ($urandom_range(0, 3) == 0) ln.push_back(8'($urandom_range(0, 255)));
    end else if (r < 72) begin
      if ($urandom_range(0, 9) == 0) ln.push_back(CH_COMMA);
      append_token(ln);
      repeat (($urandom_range(0, 7) == 0) ? 2 : 1) ln.push_back(CH_COMMA);
      append_token(ln);
      if ($urandom_range(0, 9) == 0) begin
        ln.push_back(CH_COMMA);
        append_token(ln);
      end
    end else if (r < 82) begin
      // overlong run of digits, commas and minus signs
      repeat ($urandom_range(16, 24)) begin
        case ($urandom_range(0, 5))
          0:       ln.push_back(CH_COMMA);
          1:       ln.push_back(CH_MINUS);
          default: ln.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        endcase
      end
    end else if (r < 94) begin
      repeat ($urandom_range(1, 18)) begin
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_NEWLINE) b = 8'hFF;
        ln.push_back(b);
      end
    end else begin
      append_token(ln);
      ln.push_back(CH_COMMA);
      append_token(ln);
      ln.insert($urandom_range(0, ln.size()), CH_NUL);
    end
    ln.push_back(CH_NEWLINE);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected transaction, wheel_one", wheel_one_o, 0);
      end else begin
        wheel_cmd_t e;
        e = pending_cmds.pop_front();
        if (wheel_one_o !== e.w1) report_mismatch("wheel_one", wheel_one_o, e.w1);
        if (wheel_two_o !== e.w2) report_mismatch("wheel_two", wheel_two_o, e.w2);
        if (wheel_three_o !== e.w3) report_mismatch("wheel_three", wheel_three_o, e.w3);
        if (wheel_four_o !== e.w4) report_mismatch("wheel_four", wheel_four_o, e.w4);
        if (turning_o !== e.turn) report_mismatch("turning", turning_o, e.turn);
      end
    end
  end

  // receiver stall driver, with a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    int stall_left;
    int len;
    hold_seen   = 0;
    hold_left   = 0;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        len = pick_gap(out_idle_on);
        out_stall_i = (len > 0);
        stall_left  = (len > 0) ? len - 1 : 0;
      end
    end
  end

  // main sequence
  initial begin
    logic [7:0] ln[$];
    logic [7:0] ch;
    logic [14:0] dz_plan[5];
    logic [14:0] lim_plan[5];
    bit          in_plan[5];
    bit          out_plan[5];
    int          start_items;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_in_i   = 8'd0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = 3'd0;
    pwdata      = 32'd0;
    error_count = 0;
    items_used  = 0;
    hold_req    = 0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    dz_cfg      = 15'd20;
    lim_cfg     = 15'd15000;
    clear_line();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed lines at reset settings
    add_row("R\n", -1, 1, 15000, 15000, 15000, 15000, TURN_RIGHT);
    add_row("L\n", -1, 1, -15000, -15000, -15000, -15000, TURN_LEFT);
    add_row("\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("0,0\n", -1, 1, 0, 0, 0, 0, TURN_NONE);
    add_row("19,-19\n", -1, 1, 0, 0, 0, 0, TURN_NONE);
    add_row("-19,19\n", -1, 1, 0, 0, 0, 0, TURN_NONE);
    add_row("20,0\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("32767,32767\n", -1, 1, 0, -15000, 0, 15000, TURN_NONE);
    add_row("-32767,32767\n", -1, 1, -15000, 0, 15000, 0, TURN_NONE);
    add_row("-99999,5\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("R5\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("L \n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("R?Z\n", 1, 1, 15000, 15000, 15000, 15000, TURN_RIGHT);
    add_row("5?,3000\n", 1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row(",,,70,,\t-30\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("  -300,+45\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("x,100\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("123abc,-50\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("9000\377,5\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("1234567890123456789,5\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("RRRRRRRRRRRRRRRRRRRR\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("100,-100,5000\n", -1, 0, 0, 0, 0, 0, TURN_NONE);
    add_row("+,-\n", -1, 0, 0, 0, 0, 0, TURN_NONE);

    foreach (rows[r]) begin
      for (int i = 0; i < rows[r].text.len(); i++) begin
        ch = rows[r].text[i];
        if (i == rows[r].nul_at) ch = CH_NUL;
        send_char(ch, pick_gap(in_idle_on));
      end
      if (rows[r].fixed) pending_cmds[$] = rows[r].want;
    end
    drain();

    // random phases over several settings, extremes first
    dz_plan  = '{15'd0, 15'd32767, 15'd100, 15'd1, 15'($urandom)};
    lim_plan = '{15'd32767, 15'd0, 15'd15000, 15'd1, 15'($urandom)};
    in_plan  = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    out_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_DEAD_ZONE, dz_plan[p]);
      write_reg(REG_MOTOR_LIMIT, lim_plan[p]);
      in_idle_on  = in_plan[p];
      out_idle_on = out_plan[p];
      start_items = items_used;
      if (p == 2) begin
        // long receiver hold-off while short lines keep coming
        hold_req++;
        repeat (40) begin
          ln.delete();
          ln.push_back(($urandom_range(0, 1) == 0) ? CH_R : CH_L);
          ln.push_back(CH_NEWLINE);
          foreach (ln[i]) send_char(ln[i], 0);
        end
      end
      while (items_used - start_items < PHASE_ITEMS) begin
        build_line(ln);
        foreach (ln[i]) send_char(ln[i], pick_gap(in_idle_on));
      end
      drain();
    end

    if (pending_cmds.size() != 0) report_mismatch("leftover commands", pending_cmds.size(), 0);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/owcm_pkg.sv
src/omni_wheel_command_mixer.sv
tb/testbench.sv
